// ===== rtl/sha1md_pkg.sv =====
// Package: SHA-1 constants, command type and helper functions.
`timescale 1ns / 1ps
package sha1md_pkg;
	localparam int unsigned LengthBitsDefault = 64;
	localparam int unsigned QueueDepth = 4;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [7:0]  PadByte = 8'h80;

	// one byte headed for the block buffer; fin marks the final byte of padding
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction
endpackage

// ===== rtl/sha1md_if.sv =====
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface sha1md_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sha1md_front.sv =====
// Front end: takes input transactions, counts length, generates padding bytes.
`timescale 1ns / 1ps
module sha1md_front #(
	parameter int unsigned LENGTH_BITS = sha1md_pkg::LengthBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              byte_present,
	input  logic              message_end,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output sha1md_pkg::cmd_t  cmd
);
	typedef enum logic [1:0] {TAKE, DATA, PAD, LEN} state_t;

	state_t               state_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [5:0]           pos_q;
	logic [2:0]           lcnt_q;
	logic [7:0]           byte_q;
	logic                 end_q;
	logic [63:0]          len64;
	logic                 fire;

	assign len64    = 64'(len_q);
	assign in_ready = (state_q == TAKE);
	assign fire     = cmd_valid && cmd_ready;

	always_comb begin
		cmd_valid = 1'b0;
		cmd.data  = 8'h00;
		cmd.fin   = 1'b0;
		case (state_q)
			DATA: begin
				cmd_valid = 1'b1;
				cmd.data  = byte_q;
			end
			PAD: begin
				cmd_valid = 1'b1;
				cmd.data  = end_q ? sha1md_pkg::PadByte : 8'h00;
			end
			LEN: begin
				cmd_valid = 1'b1;
				cmd.data  = len64[8*(7-lcnt_q) +: 8];
				cmd.fin   = (lcnt_q == 3'd7);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TAKE;
			len_q   <= '0;
			pos_q   <= '0;
			lcnt_q  <= '0;
			end_q   <= 1'b0;
			byte_q  <= '0;
		end else begin
			case (state_q)
				TAKE: if (in_valid) begin
					byte_q <= data_byte;
					end_q  <= message_end;
					if (byte_present) begin
						len_q   <= len_q + LENGTH_BITS'(8);
						state_q <= DATA;
					end else if (message_end) state_q <= PAD;
				end
				DATA: if (fire) begin
					pos_q   <= pos_q + 6'd1;
					state_q <= end_q ? PAD : TAKE;
				end
				PAD: if (fire) begin
					// end_q doubles as "0x80 not yet sent"
					end_q  <= 1'b0;
					pos_q  <= pos_q + 6'd1;
					lcnt_q <= '0;
					if (pos_q == 6'd55) state_q <= LEN;
				end
				LEN: if (fire) begin
					lcnt_q <= lcnt_q + 3'd1;
					pos_q  <= pos_q + 6'd1;
					if (lcnt_q == 3'd7) begin
						state_q <= TAKE;
						len_q   <= '0;
					end
				end
				default: state_q <= TAKE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LEN && fire && lcnt_q == 3'd7) |-> (pos_q == 6'd63))
		else $error("length bytes misaligned");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd_valid)
		else $error("front accepts while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PAD && fire) |=> (state_q == PAD || state_q == LEN))
		else $error("padding left early");
endmodule

// ===== rtl/sha1md_queue.sv =====
// Small FIFO between front and back.
`timescale 1ns / 1ps
module sha1md_queue #(
	parameter int unsigned DEPTH = sha1md_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  sha1md_pkg::cmd_t wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output sha1md_pkg::cmd_t rd_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	sha1md_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue overflow");
endmodule

// ===== rtl/sha1md_back.sv =====
// Back end: packs bytes into the block buffer, runs 80 rounds, emits digest.
`timescale 1ns / 1ps
module sha1md_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  sha1md_pkg::cmd_t cmd,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_number,
	output logic             last_word
);
	typedef enum logic [1:0] {FILL, ROUND, DONE, EMIT} state_t;

	state_t      state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [5:0]  pos_q;
	logic [6:0]  rnd_q;
	logic        fin_q;
	logic [2:0]  wn_q;

	logic [31:0] wx, wt, f, k, tmp;
	logic [3:0]  wi;
	logic        take;

	assign cmd_ready = (state_q == FILL);
	assign take = cmd_valid && cmd_ready;
	assign wi = rnd_q[3:0];

	always_comb begin
		wx = sha1md_pkg::rotl(w_q[wi - 4'd3] ^ w_q[wi - 4'd8] ^ w_q[wi - 4'd14]
			^ w_q[wi], 1);
		wt = (rnd_q >= 7'd16) ? wx : w_q[wi];
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = sha1md_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = sha1md_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = sha1md_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = sha1md_pkg::K3;
		end
		tmp = sha1md_pkg::rotl(a_q, 5) + f + e_q + wt + k;
	end

	assign out_valid   = (state_q == EMIT);
	assign digest_word = h_q[wn_q];
	assign word_number = wn_q;
	assign last_word   = (wn_q == 3'd4);

	// schedule buffer, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			if (pos_q[1:0] == 2'd0) w_q[pos_q[5:2]] <= {cmd.data, 24'h0};
			else w_q[pos_q[5:2]][8*(3-pos_q[1:0]) +: 8] <= cmd.data;
		end else if (state_q == ROUND && rnd_q >= 7'd16) w_q[wi] <= wx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FILL;
			pos_q <= '0; rnd_q <= '0; fin_q <= 1'b0; wn_q <= '0;
			h_q[0] <= sha1md_pkg::H0; h_q[1] <= sha1md_pkg::H1;
			h_q[2] <= sha1md_pkg::H2; h_q[3] <= sha1md_pkg::H3;
			h_q[4] <= sha1md_pkg::H4;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
		end else begin
			case (state_q)
				FILL: if (take) begin
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						fin_q <= cmd.fin;
						rnd_q <= '0;
						a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
						d_q <= h_q[3]; e_q <= h_q[4];
						state_q <= ROUND;
					end
				end
				ROUND: begin
					e_q <= d_q; d_q <= c_q; c_q <= sha1md_pkg::rotl(b_q, 30);
					b_q <= a_q; a_q <= tmp;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= DONE;
				end
				DONE: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					wn_q <= '0;
					state_q <= fin_q ? EMIT : FILL;
				end
				EMIT: if (out_ready) begin
					wn_q <= wn_q + 3'd1;
					if (wn_q == 3'd4) begin
						h_q[0] <= sha1md_pkg::H0; h_q[1] <= sha1md_pkg::H1;
						h_q[2] <= sha1md_pkg::H2; h_q[3] <= sha1md_pkg::H3;
						h_q[4] <= sha1md_pkg::H4;
						state_q <= FILL;
					end
				end
				default: state_q <= FILL;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ROUND) |-> (pos_q == 6'd0)) else $error("fill during rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.fin) |-> (pos_q == 6'd63)) else $error("final byte misplaced");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (wn_q <= 3'd4)) else $error("digest index out of range");
endmodule

// ===== rtl/sha1_message_digest_top.sv =====
// SHA-1 digest top: byte front end, command queue, compression back end.
// The front end takes a new input byte only after handing the previous one on; each
// 64-byte block then runs 80 rounds and one chaining step in the compression back end.
// After the ending transaction, padding bytes drain through the queue, the last block
// compresses, then five digest words emerge one a cycle while out_ready is high.
// Reset (arst_n low) clears all control state and loads the initial hash words.
`timescale 1ns / 1ps
module sha1_message_digest_top #(
	parameter int unsigned LENGTH_BITS = sha1md_pkg::LengthBitsDefault
) (
	input logic clk,
	input logic arst_n,
	sha1md_if.sink   in_ch,
	sha1md_if.source out_ch
);
	sha1md_pkg::cmd_t fq_data, bq_data;
	logic fq_valid, fq_ready, bq_valid, bq_ready;

	sha1md_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.data_byte(in_ch.payload.data_byte),
		.byte_present(in_ch.payload.byte_present),
		.message_end(in_ch.payload.message_end),
		.cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_data)
	);

	sha1md_queue #(.DEPTH(sha1md_pkg::QueueDepth)) u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
	);

	sha1md_back u_back (
		.clk, .arst_n,
		.cmd_valid(bq_valid), .cmd_ready(bq_ready), .cmd(bq_data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.digest_word(out_ch.payload.digest_word),
		.word_number(out_ch.payload.word_number),
		.last_word(out_ch.payload.last_word)
	);
endmodule

// ===== tb/sha1_tb_pkg.sv =====
// Testbench package: payload types of the byte input and digest output channels.
`timescale 1ns / 1ps
package sha1_tb_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} msg_byte_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} digest_out_t;
endpackage

// ===== tb/digest_checker.sv =====
// Checker: follows the byte stream, computes SHA-1 digests and compares the output words.
`timescale 1ns / 1ps
module digest_checker (
	input  logic clk,
	input  logic arst_n,
	sha1md_if    in_ch,
	sha1md_if    out_ch,
	output int   fails,
	output int   pending
);
	logic [31:0] hash_h[5];
	logic [31:0] blk_w[16];
	logic [5:0]  blk_pos;
	logic [63:0] msg_bits;
	sha1_tb_pkg::digest_out_t digest_q[$];

	function automatic logic [31:0] rol(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic start_message();
		hash_h = '{sha1md_pkg::H0, sha1md_pkg::H1, sha1md_pkg::H2, sha1md_pkg::H3,
			sha1md_pkg::H4};
		blk_pos = '0;
		msg_bits = '0;
	endtask

	task automatic compress_block();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) w[i] = blk_w[i];
		for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = sha1md_pkg::K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = sha1md_pkg::K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = sha1md_pkg::K2;
			end else begin
				f = b ^ c ^ d; k = sha1md_pkg::K3;
			end
			t = rol(a, 5) + f + e + w[i] + k;
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
	endtask

	task automatic absorb(input logic [7:0] b);
		blk_w[blk_pos[5:2]][8*(3 - blk_pos[1:0]) +: 8] = b;
		blk_pos = blk_pos + 1;
		if (blk_pos == 0) compress_block();
	endtask

	task automatic finish_message();
		logic [63:0] len;
		len = msg_bits;
		absorb(sha1md_pkg::PadByte);
		while (blk_pos != 56) absorb(8'h00);
		for (int i = 0; i < 8; i++) absorb(len[8*(7 - i) +: 8]);
		for (int i = 0; i < 5; i++)
			digest_q.push_back('{digest_word: hash_h[i], word_number: 3'(i),
				last_word: (i == 4)});
		start_message();
	endtask

	initial begin
		fails = 0;
		pending = 0;
		start_message();
	end

	always @(posedge clk) begin
		sha1_tb_pkg::msg_byte_t   ib;
		sha1_tb_pkg::digest_out_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			if (digest_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected digest word %h num %0d last %b",
						got.digest_word, got.word_number, got.last_word);
			end else begin
				want = digest_q.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= 10)
						$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
							want.digest_word, want.word_number, want.last_word,
							got.digest_word, got.word_number, got.last_word);
				end
			end
		end
		if (arst_n && in_ch.valid && in_ch.ready) begin
			ib = in_ch.payload;
			if (ib.byte_present) begin
				absorb(ib.data_byte);
				msg_bits = msg_bits + 64'd8;
			end
			if (ib.message_end) finish_message();
		end
		pending = digest_q.size();
	end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, byte stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps
module tb_top;
	logic clk;
	logic arst_n;
	int   fails, pending;
	int   cycles;
	int   items_sent;
	bit   stim_done;
	bit   hold_go;

	sha1md_if #(.payload_t(sha1_tb_pkg::msg_byte_t))   in_ch ();
	sha1md_if #(.payload_t(sha1_tb_pkg::digest_out_t)) out_ch ();

	sha1_message_digest_top dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	digest_checker checker_i (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fails(fails), .pending(pending));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		out_ch.ready <= 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// one transaction; valid stays high straight into the next item when no gap follows
	task automatic send(input logic [7:0] b, input logic present, input logic fin,
		input int gap);
		in_ch.valid <= 1'b1;
		in_ch.payload <= '{data_byte: b, byte_present: present, message_end: fin};
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= '{data_byte: 8'($urandom), byte_present: 1'($urandom),
				message_end: 1'($urandom)};
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_message(input int len, input bit burst);
		bit fused;
		fused = (len > 0) && $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			if (!burst && $urandom_range(0, 9) == 0)
				send(8'($urandom), 1'b0, 1'b0, gap_len());
			send(8'($urandom), 1'b1, fused && (i == len - 1), burst ? 0 : gap_len());
		end
		if (!fused) send(8'($urandom), 1'b0, 1'b1, burst ? 0 : gap_len());
	endtask

	// stimulus
	initial begin
		int len, r;
		items_sent = 0;
		stim_done = 0;
		hold_go = 0;
		@(posedge arst_n);
		@(posedge clk);
		// empty message, single extreme bytes with end, an idle item, "abc"
		send(8'h00, 1'b0, 1'b1, 0);
		send(8'hFF, 1'b1, 1'b1, 1);
		send(8'h00, 1'b1, 1'b1, 0);
		send(8'hA5, 1'b0, 1'b0, 2);
		send(8'h61, 1'b1, 1'b0, 0);
		send(8'h62, 1'b1, 1'b0, 0);
		send(8'h63, 1'b1, 1'b0, 0);
		send(8'h5A, 1'b0, 1'b1, 0);
		// pad boundaries: 55 fits one block, 56 spills into a second
		send_message(55, 1);
		send_message(56, 1);
		hold_go = 1;
		while (items_sent < 360) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				case ($urandom_range(0, 5))
					0: len = 55;
					1: len = 56;
					2: len = 63;
					3: len = 64;
					4: len = 119;
					default: len = 120;
				endcase
			end else
				len = $urandom_range(0, 30);
			send_message(len, $urandom_range(0, 3) == 0);
		end
		in_ch.valid <= 1'b0;
		stim_done = 1;
	end

	// output back-pressure, with one long hold-off while input keeps coming
	initial begin
		bit held;
		int n;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (hold_go && !held) begin
				held = 1;
				out_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end else begin
				n = gap_len();
				out_ch.ready <= (n == 0);
				repeat (n == 0 ? 1 : n) @(posedge clk);
			end
		end
	end

	// verdict and cycle limit
	initial begin
		cycles = 0;
		fork
			begin
				wait (stim_done);
				@(posedge clk);
				while (pending != 0) @(posedge clk);
				repeat (300) @(posedge clk);
				if (fails == 0 && pending == 0)
					$display("end of test: clean");
				else
					$display("end of test: mismatches");
				$finish;
			end
			begin
				while (cycles < 300000) begin
					@(posedge clk);
					cycles++;
				end
				$display("end of test: mismatches");
				$finish;
			end
		join
	end
endmodule
